// ===== design/dps_pkg.sv =====
// Shared widths, register indexes and configuration type for the distance PID step unit.
package dps_pkg;

	localparam int ERR_W   = 24;
	localparam int FRAC_W  = 16;
	localparam int INT_W   = ERR_W + 1;
	localparam int GAIN_W  = 24;
	localparam int LIM_W   = 24;
	localparam int ZONE_W  = 23;
	localparam int SPD_W   = 15;
	localparam int DRV_W   = 16;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int IN_TDATA_W  = ((ERR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DRV_W + 1 + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [IDX_W-1:0] REG_INT_LIM  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INT_ZONE = 3'd4;
	localparam logic [IDX_W-1:0] REG_DONE_THR = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_OUT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_MAX_SPD  = 3'd7;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [LIM_W-1:0]  integral_limit;
		logic [ZONE_W-1:0] integral_zone;
		logic [ZONE_W-1:0] done_threshold;
		logic [SPD_W-1:0]  min_output;
		logic [SPD_W-1:0]  max_speed;
	} cfg_t;

endpackage

// ===== design/dps_regs.sv =====
// Configuration register file for the distance PID step unit.
module dps_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dps_pkg::IDX_W-1:0] cfg_index,
	input  logic [dps_pkg::CFG_W-1:0] cfg_data,
	output dps_pkg::cfg_t             cfg
);
	import dps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= GAIN_W'(327680);
			cfg_q.gain_i         <= GAIN_W'(655);
			cfg_q.gain_d         <= GAIN_W'(65536);
			cfg_q.integral_limit <= LIM_W'(1024000);
			cfg_q.integral_zone  <= ZONE_W'(2560);
			cfg_q.done_threshold <= ZONE_W'(64);
			cfg_q.min_output     <= SPD_W'(512);
			cfg_q.max_speed      <= SPD_W'(25600);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:   cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:   cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:   cfg_q.gain_d         <= cfg_data[GAIN_W-1:0];
				REG_INT_LIM:  cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				REG_INT_ZONE: cfg_q.integral_zone  <= cfg_data[ZONE_W-1:0];
				REG_DONE_THR: cfg_q.done_threshold <= cfg_data[ZONE_W-1:0];
				REG_MIN_OUT:  cfg_q.min_output     <= cfg_data[SPD_W-1:0];
				REG_MAX_SPD:  cfg_q.max_speed      <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/distance_pid_step_unit.sv =====
// Top level of the distance PID step unit: error item in, drive item out.
// Usage:
//   s_axis carries one signed error item per control tick; m_axis returns one
//   item per error: a signed drive value and a done flag, in input order.
//   The cfg port writes one gain or limit per cycle; write only while idle.
// Pipeline: an accepted error passes through the input register, the
//   integral/derivative stage, the product stage and the result register.
// Throughput: one item per cycle while m_axis_tready holds. The integral and
//   previous error update as each item leaves the first stage, which sets
//   the rate; the three gain products run in parallel in the product stage.
// Reset: arst_n clears the pipeline valids, the integral and the previous
//   error, and loads the default gains and limits.
// Stall: each stage moves when the one after it is empty or moving, so empty
//   stages still take items while a result waits on m_axis_tready; once all
//   stages are full, s_axis_tready drops until the receiver takes the result.
module distance_pid_step_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [23:0] error_sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] drive_value, [16] done_res
	input  logic                            cfg_we,
	input  logic [dps_pkg::IDX_W-1:0]       cfg_index,
	input  logic [dps_pkg::CFG_W-1:0]       cfg_data
);
	import dps_pkg::*;

	localparam int PP_W  = GAIN_W + 1 + ERR_W;
	localparam int PI_W  = GAIN_W + 1 + INT_W;
	localparam int SUM_W = PI_W + 2;
	localparam int ACC_W = INT_W + 1;

	cfg_t cfg;

	dps_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en1, en2, en3, en_out;

	assign en_out        = !out_valid_q || m_axis_tready;
	assign en3           = !v_s3 || en_out;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	// stage 1: error register
	logic signed [ERR_W-1:0] e_s1;

	// state
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [INT_W-1:0] integ_q;

	logic signed [INT_W-1:0] e_ext, neg_e, prev_ext, deriv_c;
	logic [ERR_W-1:0]        mag;
	logic                    done_c, in_zone;
	logic signed [ACC_W-1:0] acc, pre, lim, clamped;
	logic signed [INT_W-1:0] integ_next;

	always_comb begin
		e_ext    = INT_W'(e_s1);
		neg_e    = -e_ext;
		prev_ext = INT_W'(prev_err_q);
		mag      = e_s1[ERR_W-1] ? neg_e[ERR_W-1:0] : e_s1[ERR_W-1:0];
		done_c   = mag <= {{(ERR_W-ZONE_W){1'b0}}, cfg.done_threshold};
		in_zone  = mag < {{(ERR_W-ZONE_W){1'b0}}, cfg.integral_zone};
		acc      = ACC_W'(integ_q) + ACC_W'(e_s1);
		pre      = in_zone ? acc : '0;
		lim      = $signed({{(ACC_W-LIM_W){1'b0}}, cfg.integral_limit});
		if (pre > lim)
			clamped = lim;
		else if (pre < -lim)
			clamped = -lim;
		else
			clamped = pre;
		integ_next = done_c ? '0 : clamped[INT_W-1:0];
		deriv_c    = e_ext - prev_ext;
	end

	// stage 2: integral and derivative
	logic signed [ERR_W-1:0] e_s2;
	logic signed [INT_W-1:0] integ_s2, deriv_s2;
	logic                    done_s2;

	// stage 3: gain products
	logic signed [PP_W-1:0] prod_p_s3;
	logic signed [PI_W-1:0] prod_i_s3, prod_d_s3;
	logic                   done_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			prev_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (en1)
				v_s1 <= s_axis_tvalid;
			if (en2) begin
				v_s2 <= v_s1;
				if (v_s1) begin
					prev_err_q <= e_s1;
					integ_q    <= integ_next;
				end
			end
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid)
			e_s1 <= $signed(s_axis_tdata[ERR_W-1:0]);
		if (en2 && v_s1) begin
			e_s2     <= e_s1;
			integ_s2 <= integ_next;
			deriv_s2 <= deriv_c;
			done_s2  <= done_c;
		end
		if (en3 && v_s2) begin
			prod_p_s3 <= PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(e_s2);
			prod_i_s3 <= PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(integ_s2);
			prod_d_s3 <= PI_W'($signed({1'b0, cfg.gain_d})) * PI_W'(deriv_s2);
			done_s3   <= done_s2;
		end
	end

	// final stage: sum, floor shift, clamp, minimum magnitude, zero when done
	logic signed [SUM_W-1:0] sum, shifted, max_s, clip;
	logic signed [DRV_W-1:0] drv_c, min_s, drive_c;

	always_comb begin
		sum     = SUM_W'(prod_p_s3) + SUM_W'(prod_i_s3) + SUM_W'(prod_d_s3);
		shifted = sum >>> FRAC_W;
		max_s   = $signed({{(SUM_W-SPD_W){1'b0}}, cfg.max_speed});
		if (shifted > max_s)
			clip = max_s;
		else if (shifted < -max_s)
			clip = -max_s;
		else
			clip = shifted;
		drv_c = $signed(clip[DRV_W-1:0]);
		min_s = $signed({{(DRV_W-SPD_W){1'b0}}, cfg.min_output});
		if (done_s3)
			drive_c = '0;
		else if (drv_c > 0 && drv_c < min_s)
			drive_c = min_s;
		else if (drv_c < 0 && drv_c > -min_s)
			drive_c = -min_s;
		else
			drive_c = drv_c;
	end

	logic signed [DRV_W-1:0] drive_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en_out)
			out_valid_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			drive_q <= drive_c;
			done_q  <= done_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-DRV_W-1){1'b0}}, done_q, drive_q};

endmodule
